// ===== src/rpd_pkg.sv =====
`timescale 1ns / 1ps
package rpd_pkg;

  localparam int MaxHeadersDef = 8;
  localparam int MaxQueuedDef  = 8;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TRUNC    = 3'd1;
  localparam logic [2:0] ST_MANY     = 3'd2;
  localparam logic [2:0] ST_OVERRUN  = 3'd3;
  localparam logic [2:0] ST_QFULL    = 3'd4;
  localparam logic [2:0] ST_OVERSIZE = 3'd5;

  // one stored header
  typedef struct packed {
    logic [6:0]  pt;
    logic [13:0] tso;
    logic [9:0]  len;
  } ent_t;

  // packet summary handed from parser to walker
  typedef struct packed {
    logic        oversize;
    logic        trunc;
    logic        in_over;
    logic [15:0] len;
    logic [15:0] ovf_pos;
    logic [6:0]  ptype;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [1:0]  flags;
  } pkt_info_t;

  // one descriptor
  typedef struct packed {
    logic [2:0]  status;
    logic        prim;
    logic [6:0]  pt;
    logic [15:0] off;
    logic [15:0] len;
    logic [31:0] ts;
    logic [15:0] seq;
    logic [1:0]  flags;
    logic        last;
  } res_t;

endpackage

// ===== src/rpd_table.sv =====
`timescale 1ns / 1ps
module rpd_table import rpd_pkg::*; #(
  parameter int MAX_HEADERS = MaxHeadersDef,
  localparam int HIW = (MAX_HEADERS > 1) ? $clog2(MAX_HEADERS) : 1
) (
  input  logic           clk,
  input  logic           we,
  input  logic [HIW-1:0] waddr,
  input  ent_t           wdata,
  input  logic           re,
  input  logic [HIW-1:0] raddr,
  output ent_t           rdata
);

  ent_t mem [MAX_HEADERS];

  // header storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rpd_parser.sv =====
`timescale 1ns / 1ps
module rpd_parser import rpd_pkg::*; #(
  parameter int MAX_HEADERS = MaxHeadersDef,
  localparam int HIW = (MAX_HEADERS > 1) ? $clog2(MAX_HEADERS) : 1,
  localparam int HCW = $clog2(MAX_HEADERS + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           sop,
  input  logic           eop,
  input  logic [15:0]    in_seq,
  input  logic [31:0]    in_ts,
  input  logic [1:0]     in_flags,
  output logic           we,
  output logic [HIW-1:0] waddr,
  output ent_t           wdata,
  output logic           done,
  output logic [HCW-1:0] hcount,
  output pkt_info_t      info
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HSTART = 3'd1;
  localparam logic [2:0] PH_HBYTES = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_OVER   = 3'd4;

  logic [2:0]     phase, phase_next, ph_work;
  logic [HCW-1:0] count, count_next;
  logic [15:0]    pos, pos_next, ovf, ovf_next;
  logic [1:0]     hbi, hbi_next;
  logic [23:0]    asm_reg, asm_next, low;
  logic [6:0]     ptype, ptype_next;
  logic [15:0]    seq, seq_next;
  logic [31:0]    ts, ts_next;
  logic [1:0]     flags, flags_next;
  logic           over5, over5_next;
  logic           done_next;
  logic [2:0]     term, term_next;

  // byte parse
  always_comb begin
    phase_next = phase;
    count_next = count;
    pos_next   = pos;
    ovf_next   = ovf;
    hbi_next   = hbi;
    asm_next   = asm_reg;
    ptype_next = ptype;
    seq_next   = seq;
    ts_next    = ts;
    flags_next = flags;
    over5_next = over5;
    term_next  = term;
    done_next  = 1'b0;
    we         = 1'b0;
    waddr      = count[HIW-1:0];
    low        = {asm_reg[15:0], data_byte};
    wdata      = '{pt: asm_reg[22:16], tso: low[23:10], len: low[9:0]};
    ph_work    = phase;
    if (accept) begin
      if (sop) begin
        count_next = '0;
        pos_next   = '0;
        ovf_next   = '0;
        hbi_next   = '0;
        asm_next   = '0;
        ptype_next = '0;
        over5_next = 1'b0;
        seq_next   = in_seq;
        ts_next    = in_ts;
        flags_next = in_flags;
        ph_work    = PH_HSTART;
        phase_next = PH_HSTART;
        low        = {8'd0, 8'd0, data_byte};
      end
      if (ph_work != PH_IDLE) begin
        if (!over5_next) begin
          if (pos_next == 16'hffff) begin
            over5_next = 1'b1;
          end else begin
            pos_next = pos_next + 16'd1;
            case (ph_work)
              PH_HSTART: begin
                if (data_byte[7]) begin
                  if (32'(count_next) >= MAX_HEADERS) begin
                    ovf_next   = pos_next - 16'd1;
                    phase_next = PH_OVER;
                  end else begin
                    asm_next   = {16'd0, data_byte};
                    hbi_next   = 2'd1;
                    phase_next = PH_HBYTES;
                  end
                end else begin
                  ptype_next = data_byte[6:0];
                  phase_next = PH_DATA;
                end
              end
              PH_HBYTES: begin
                if (hbi < 2'd3) begin
                  asm_next = {asm_reg[15:0], data_byte};
                  hbi_next = hbi + 2'd1;
                end else begin
                  we         = 1'b1;
                  count_next = count + 1'b1;
                  hbi_next   = '0;
                  phase_next = PH_HSTART;
                end
              end
              default: ;
            endcase
          end
        end
        if (eop) begin
          done_next  = 1'b1;
          term_next  = phase_next;
          phase_next = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      count <= '0;
      pos   <= '0;
      ovf   <= '0;
      hbi   <= '0;
      asm_reg <= '0;
      ptype <= '0;
      seq   <= '0;
      ts    <= '0;
      flags <= '0;
      over5 <= 1'b0;
      term  <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      count <= count_next;
      pos   <= pos_next;
      ovf   <= ovf_next;
      hbi   <= hbi_next;
      asm_reg <= asm_next;
      ptype <= ptype_next;
      seq   <= seq_next;
      ts    <= ts_next;
      flags <= flags_next;
      over5 <= over5_next;
      term  <= term_next;
      done  <= done_next;
    end
  end

  // packet summary
  assign hcount = count;
  assign info = '{oversize: over5,
                  trunc:    (term == PH_HSTART) || (term == PH_HBYTES),
                  in_over:  (term == PH_OVER),
                  len:      pos,
                  ovf_pos:  ovf,
                  ptype:    ptype,
                  seq:      seq,
                  ts:       ts,
                  flags:    flags};

endmodule

// ===== src/rpd_walker.sv =====
`timescale 1ns / 1ps
module rpd_walker import rpd_pkg::*; #(
  parameter int MAX_HEADERS = MaxHeadersDef,
  parameter int MAX_QUEUED  = MaxQueuedDef,
  localparam int HIW = (MAX_HEADERS > 1) ? $clog2(MAX_HEADERS) : 1,
  localparam int HCW = $clog2(MAX_HEADERS + 1),
  localparam int QCW = $clog2(MAX_QUEUED + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [HCW-1:0] hcount,
  input  pkt_info_t      info,
  output logic           re,
  output logic [HIW-1:0] raddr,
  input  ent_t           rdata,
  output logic           busy,
  output logic           out_valid,
  input  logic           out_ready,
  output res_t           out_res
);

  localparam logic [2:0] W_IDLE = 3'd0;
  localparam logic [2:0] W_ERR  = 3'd1;
  localparam logic [2:0] W_RD   = 3'd2;
  localparam logic [2:0] W_EV   = 3'd3;
  localparam logic [2:0] W_TAIL = 3'd4;
  localparam logic [2:0] W_PRIM = 3'd5;

  logic [2:0]     state, state_next;
  logic           pass, pass_next;
  logic [HCW-1:0] idx, idx_next;
  logic [16:0]    off, off_next, off_init;
  logic [QCW-1:0] bc, bc_next;
  logic [2:0]     err, err_next;
  logic [15:0]    exp_seq, exp_seq_next;
  logic           seq_known, seq_known_next;
  logic [31:0]    last_ts, last_ts_next;
  logic           ts_known, ts_known_next;
  logic           out_free, load;
  res_t           res_next;
  logic signed [17:0] rem;
  logic [31:0]    bts, dts;
  logic           gap, qual, overrun, qfull;

  assign out_free = !out_valid || out_ready;
  assign off_init = 17'({hcount, 2'b00}) + 17'd1;
  assign gap      = seq_known && (info.seq != exp_seq);

  // evaluation of the entry just read
  always_comb begin
    rem     = 18'({2'b00, info.len}) - 18'({1'b0, off});
    bts     = info.ts - {18'd0, rdata.tso};
    dts     = bts - last_ts;
    overrun = $signed({8'd0, rdata.len}) > rem;
    qual    = gap && (rdata.pt == info.ptype) && (rdata.len != 10'd0) &&
              (!ts_known || ((dts != 32'd0) && !dts[31]));
    qfull   = 32'(bc) >= MAX_QUEUED;
  end

  // walk sequencer
  always_comb begin
    state_next     = state;
    pass_next      = pass;
    idx_next       = idx;
    off_next       = off;
    bc_next        = bc;
    err_next       = err;
    exp_seq_next   = exp_seq;
    seq_known_next = seq_known;
    last_ts_next   = last_ts;
    ts_known_next  = ts_known;
    load           = 1'b0;
    res_next       = '0;
    re             = 1'b0;
    raddr          = idx[HIW-1:0];
    case (state)
      W_IDLE: begin
        if (start) begin
          pass_next = 1'b0;
          idx_next  = '0;
          off_next  = off_init;
          bc_next   = '0;
          if (info.oversize) begin
            err_next   = ST_OVERSIZE;
            state_next = W_ERR;
          end else if (info.trunc) begin
            err_next   = ST_TRUNC;
            state_next = W_ERR;
          end else if (info.in_over) begin
            err_next   = ({1'b0, info.len} <= {1'b0, info.ovf_pos} + 17'd4) ?
                         ST_TRUNC : ST_MANY;
            state_next = W_ERR;
          end else begin
            state_next = (hcount == '0) ? W_TAIL : W_RD;
          end
        end
      end
      W_ERR: begin
        if (out_free) begin
          load            = 1'b1;
          res_next.status = err;
          res_next.last   = 1'b1;
          state_next      = W_IDLE;
        end
      end
      W_RD: begin
        re         = 1'b1;
        state_next = W_EV;
      end
      W_EV: begin
        if (!pass) begin
          if (overrun) begin
            err_next   = ST_OVERRUN;
            state_next = W_ERR;
          end else if (qual && qfull) begin
            err_next   = ST_QFULL;
            state_next = W_ERR;
          end else begin
            bc_next    = bc + QCW'(qual);
            off_next   = off + 17'(rdata.len);
            idx_next   = idx + 1'b1;
            state_next = (idx_next == hcount) ? W_TAIL : W_RD;
          end
        end else if (!qual || out_free) begin
          if (qual) begin
            load         = 1'b1;
            res_next.pt  = rdata.pt;
            res_next.off = off[15:0];
            res_next.len = 16'(rdata.len);
            res_next.ts  = bts;
            res_next.seq = info.seq - 16'(hcount - idx);
          end
          off_next   = off + 17'(rdata.len);
          idx_next   = idx + 1'b1;
          state_next = (idx_next == hcount) ? W_TAIL : W_RD;
        end
      end
      W_TAIL: begin
        if (!pass) begin
          if (rem < 0) begin
            err_next   = ST_OVERRUN;
            state_next = W_ERR;
          end else if (qfull) begin
            err_next   = ST_QFULL;
            state_next = W_ERR;
          end else begin
            pass_next  = 1'b1;
            idx_next   = '0;
            off_next   = off_init;
            state_next = (hcount == '0) ? W_PRIM : W_RD;
          end
        end else begin
          state_next = W_PRIM;
        end
      end
      W_PRIM: begin
        if (out_free) begin
          load           = 1'b1;
          res_next.prim  = 1'b1;
          res_next.pt    = info.ptype;
          res_next.off   = off[15:0];
          res_next.len   = rem[15:0];
          res_next.ts    = info.ts;
          res_next.seq   = info.seq;
          res_next.flags = info.flags;
          res_next.last  = 1'b1;
          exp_seq_next   = info.seq + 16'd1;
          seq_known_next = 1'b1;
          last_ts_next   = info.ts;
          ts_known_next  = 1'b1;
          state_next     = W_IDLE;
        end
      end
      default: state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= W_IDLE;
      pass      <= 1'b0;
      idx       <= '0;
      off       <= '0;
      bc        <= '0;
      err       <= ST_OK;
      exp_seq   <= '0;
      seq_known <= 1'b0;
      last_ts   <= '0;
      ts_known  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pass      <= pass_next;
      idx       <= idx_next;
      off       <= off_next;
      bc        <= bc_next;
      err       <= err_next;
      exp_seq   <= exp_seq_next;
      seq_known <= seq_known_next;
      last_ts   <= last_ts_next;
      ts_known  <= ts_known_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res_next;
    end
  end

  assign busy = (state != W_IDLE);

endmodule

// ===== src/red_payload_depacketizer.sv =====
`timescale 1ns / 1ps
// Walks the header chain of a redundant-audio payload fed one byte per transaction on the
// slave stream, storing each 4-byte block header in a small header memory, and at the packet's
// last byte emits on the master stream either one error transaction or a burst of block
// descriptors (recovered redundant blocks after a sequence gap, then the primary, which carries
// tlast). Payload bytes are taken one per cycle; after the last byte the input stalls while the
// header memory is scanned twice (a check pass, then a descriptor pass) through its one
// registered read port, and stays stalled through any output back-pressure.
module red_payload_depacketizer import rpd_pkg::*; #(
  parameter int MAX_HEADERS = MaxHeadersDef,
  parameter int MAX_QUEUED  = MaxQueuedDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // data_byte, sequence_req, timestamp, packet_flags, zero pad
  input  logic        s_tuser,  // start_of_packet
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,  // payload_type, block_offset, block_length, block_timestamp,
                                // block_sequence, block_flags, zero pad
  output logic [3:0]  m_tuser,  // status, is_primary
  output logic        m_tlast
);

  localparam int HIW = (MAX_HEADERS > 1) ? $clog2(MAX_HEADERS) : 1;
  localparam int HCW = $clog2(MAX_HEADERS + 1);

  logic           accept, done, busy, we, re;
  logic [HIW-1:0] waddr, raddr;
  ent_t           wdata, rdata;
  logic [HCW-1:0] hcount;
  pkt_info_t      info;
  res_t           res;

  assign s_tready = !(done || busy);
  assign accept   = s_tvalid && s_tready;

  rpd_parser #(.MAX_HEADERS(MAX_HEADERS)) u_parser (
    .clk(clk), .rst(rst), .accept(accept),
    .data_byte(s_tdata[7:0]), .sop(s_tuser), .eop(s_tlast),
    .in_seq(s_tdata[23:8]), .in_ts(s_tdata[55:24]), .in_flags(s_tdata[57:56]),
    .we(we), .waddr(waddr), .wdata(wdata),
    .done(done), .hcount(hcount), .info(info)
  );

  rpd_table #(.MAX_HEADERS(MAX_HEADERS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  rpd_walker #(.MAX_HEADERS(MAX_HEADERS), .MAX_QUEUED(MAX_QUEUED)) u_walker (
    .clk(clk), .rst(rst), .start(done), .hcount(hcount), .info(info),
    .re(re), .raddr(raddr), .rdata(rdata), .busy(busy),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  // result packing
  assign m_tdata = {7'd0, res.flags, res.seq, res.ts, res.len, res.off, res.pt};
  assign m_tuser = {res.prim, res.status};
  assign m_tlast = res.last;

endmodule

// ===== src/rpd_checker.sv =====
`timescale 1ns / 1ps
module rpd_checker import rpd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed under stall");

  // an error ends the packet
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] != ST_OK) |-> m_tlast)
    else $error("error result without tlast");

  // an error carries no descriptor
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] != ST_OK) |-> (m_tdata == '0) && !m_tuser[3])
    else $error("error result with descriptor fields");

  // the primary is always the final descriptor
  a_prim_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] == ST_OK) |-> (m_tuser[3] == m_tlast))
    else $error("primary and tlast disagree");

endmodule

bind red_payload_depacketizer rpd_checker u_rpd_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
